FILE: sv/lzss_stream_decompressor_unit_defines.svh
// Assertion macros shared by the LZSS stream decompressor RTL.
`ifndef LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk_i outside reset.
`define LZSD_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk_i outside reset.
`define LZSD_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

FILE: sv/lzsd_pkg.sv
// Shared types and constants of the LZSS stream decompressor.
`default_nettype none
package lzsd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_SIZE   = 2'd1;
  localparam status_t STATUS_OFFSET = 2'd2;

  localparam int unsigned DIST_W    = 12;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned SEEN_W    = 17;
  localparam logic [LEN_W-1:0] LEN_BIAS = 5'd3;
  localparam logic [COUNT_W-1:0] MAX_OUTPUT_RESET = 16'hC800;

endpackage
`default_nettype wire

FILE: sv/lzsd_history.sv
// History memory: one write port and one read port with registered read data.
`default_nettype none
module lzsd_history #(
  parameter int unsigned Depth = 4096
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  lzsd_pkg::byte_t          wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output lzsd_pkg::byte_t          rdata_o
);

  lzsd_pkg::byte_t mem_q [Depth];
  lzsd_pkg::byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds between reads so a stalled consumer can keep using it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/lzss_stream_decompressor_unit.sv
// Top level of the LZSS stream decompressor (12-bit distance, 4-bit length).
// Usage: compressed bytes enter on the s_axis channel, one byte per transaction, with
// s_axis_tlast_i on the final byte of a stream. Decompressed bytes leave on m_axis, one
// per transaction, followed by one closing transaction with m_axis_tlast_o high that
// carries the status and the kept byte count. The cfg channel writes max_output; it is
// always ready and should only be written while the block is idle with no result owed.
// Flow: each input byte is accepted in ST_IDLE and decoded in ST_PARSE. A literal is
// written to the output register during its decode when that register is free. A
// back-reference copies one byte at a time through the single history memory port pair:
// ST_COPY_RD issues the read, ST_COPY_WR writes the byte back and emits it, and a last
// ST_COPY_RD ends the copy. The closing transaction is loaded from ST_END.
// A literal is registered in byte_q, then loaded into the output register from ST_PARSE;
// a copy's first byte goes through ST_PARSE, ST_COPY_RD, then ST_COPY_WR before it appears.
// Reset clears all parse state, the counters and the output register and loads
// max_output with 51200. History contents are not cleared; an entry is only read after
// being written in the current stream, so no clearing pass is needed.
// Stalls: results sit in a single output register. When the receiver holds
// m_axis_tready_i low, decoding pauses on the next byte it must emit, and s_axis_tready_o
// stays low until the current input byte is fully handled.
`default_nettype none
`include "lzss_stream_decompressor_unit_defines.svh"
module lzss_stream_decompressor_unit #(
  parameter int unsigned HISTORY_DEPTH = 4096
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input stream. tdata: [7:0] in_byte. tlast: in_last.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,
  input  wire         s_axis_tlast_i,
  // Output stream. tdata: [7:0] out_byte, [9:8] out_status, [25:10] out_count,
  // [31:26] zero. tlast: out_end.
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  // Configuration write channel: max_output.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_END
  } state_e;

  typedef enum logic [2:0] {
    PH_HDR_LO,
    PH_HDR_HI,
    PH_FLAG,
    PH_TOKEN,
    PH_REF_HI
  } phase_e;

  state_e                              state_q;
  phase_e                              phase_q;
  lzsd_pkg::byte_t                     byte_q;
  logic                                last_q;
  logic [lzsd_pkg::COUNT_W-1:0]        max_output_q;
  logic [lzsd_pkg::COUNT_W-1:0]        out_total_q;
  lzsd_pkg::byte_t                     flag_bits_q;
  logic [3:0]                          flag_index_q;
  lzsd_pkg::byte_t                     pending_q;
  logic [lzsd_pkg::COUNT_W-1:0]        hdr_len_q;
  logic [lzsd_pkg::SEEN_W-1:0]         seen_q;
  lzsd_pkg::status_t                   error_q;
  logic [AddrW-1:0]                    src_q;
  logic [lzsd_pkg::LEN_W-1:0]          len_q;

  logic                                out_valid_q;
  lzsd_pkg::byte_t                     out_byte_q;
  logic                                out_end_q;
  lzsd_pkg::status_t                   out_status_q;
  logic [lzsd_pkg::COUNT_W-1:0]        out_count_q;

  logic                                out_free;
  logic                                room;
  logic [lzsd_pkg::DIST_W-1:0]         ref_off;
  logic [lzsd_pkg::LEN_W-1:0]          ref_len;
  logic                                lit_want;
  logic                                lit_emit;
  logic                                copy_emit;
  logic                                hist_we;
  lzsd_pkg::byte_t                     hist_wdata;
  logic                                hist_re;
  lzsd_pkg::byte_t                     hist_rdata;
  logic [3:0]                          flag_index_inc;
  phase_e                              phase_after_bit;
  lzsd_pkg::status_t                   end_status;
  logic                                end_load;
  state_e                              done_state;

  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign room      = out_total_q < max_output_q;
  // Distance is stored minus one: zero points at the previous output byte.
  assign ref_off   = {byte_q, pending_q[7:4]};
  assign ref_len   = {1'b0, pending_q[3:0]} + lzsd_pkg::LEN_BIAS;

  // A literal is written only while the stream is clean and under the output limit.
  assign lit_want  = (state_q == ST_PARSE) && (phase_q == PH_TOKEN) && flag_bits_q[7] &&
                     (error_q == lzsd_pkg::STATUS_OK) && room;
  assign lit_emit  = lit_want && out_free;
  assign copy_emit = (state_q == ST_COPY_WR) && out_free;

  assign hist_we    = lit_emit || copy_emit;
  assign hist_wdata = lit_emit ? byte_q : hist_rdata;
  // The copy reads one entry in ST_COPY_RD, then writes it back from ST_COPY_WR, so a read never
  // meets a write to the same entry in the same cycle, even for overlapping copies.
  assign hist_re    = (state_q == ST_COPY_RD) && (len_q != '0) && room;

  assign flag_index_inc  = flag_index_q + 4'd1;
  assign phase_after_bit = (flag_index_inc >= 4'd8) ? PH_FLAG : PH_TOKEN;

  // Once an input byte is fully handled, the stream either closes or takes the next byte.
  assign done_state = last_q ? ST_END : ST_IDLE;

  // A size mismatch overrides any error; a stream ending on the first byte of a
  // back-reference counts as truncated.
  always_comb begin
    if (seen_q != ({1'b0, hdr_len_q} + lzsd_pkg::SEEN_W'(2))) begin
      end_status = lzsd_pkg::STATUS_SIZE;
    end else if ((phase_q == PH_REF_HI) && (error_q == lzsd_pkg::STATUS_OK)) begin
      end_status = lzsd_pkg::STATUS_SIZE;
    end else begin
      end_status = error_q;
    end
  end

  assign end_load = (state_q == ST_END) && out_free;

  lzsd_history #(
    .Depth (HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (out_total_q[AddrW-1:0]),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (src_q),
    .rdata_o (hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HDR_LO;
      byte_q       <= '0;
      last_q       <= 1'b0;
      max_output_q <= lzsd_pkg::MAX_OUTPUT_RESET;
      out_total_q  <= '0;
      flag_bits_q  <= '0;
      flag_index_q <= '0;
      pending_q    <= '0;
      hdr_len_q    <= '0;
      seen_q       <= '0;
      error_q      <= lzsd_pkg::STATUS_OK;
      src_q        <= '0;
      len_q        <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_end_q    <= 1'b0;
      out_status_q <= lzsd_pkg::STATUS_OK;
      out_count_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_output_q <= cfg_data_i;
      end

      // The output register loads a byte, loads the closing result, or drains.
      if (hist_we) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= hist_wdata;
        out_end_q    <= 1'b0;
        out_status_q <= lzsd_pkg::STATUS_OK;
        out_count_q  <= '0;
        out_total_q  <= out_total_q + lzsd_pkg::COUNT_W'(1);
      end else if (end_load) begin
        out_valid_q  <= 1'b1;
        out_byte_q   <= '0;
        out_end_q    <= 1'b1;
        out_status_q <= end_status;
        out_count_q  <= out_total_q;
        out_total_q  <= '0;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            byte_q  <= s_axis_tdata_i;
            last_q  <= s_axis_tlast_i;
            if (seen_q != '1) begin
              seen_q <= seen_q + lzsd_pkg::SEEN_W'(1);
            end
            state_q <= ST_PARSE;
          end
        end

        ST_PARSE: begin
          unique case (phase_q)
            PH_HDR_LO: begin
              hdr_len_q <= {8'd0, byte_q};
              phase_q   <= PH_HDR_HI;
              state_q   <= done_state;
            end
            PH_HDR_HI: begin
              hdr_len_q[15:8] <= byte_q;
              phase_q         <= PH_FLAG;
              state_q         <= done_state;
            end
            PH_FLAG: begin
              flag_bits_q  <= byte_q;
              flag_index_q <= '0;
              phase_q      <= PH_TOKEN;
              state_q      <= done_state;
            end
            PH_TOKEN: begin
              if (flag_bits_q[7]) begin
                // A literal waits here until the output register frees up.
                if (!(lit_want && !out_free)) begin
                  flag_bits_q  <= {flag_bits_q[6:0], 1'b0};
                  flag_index_q <= flag_index_inc;
                  phase_q      <= phase_after_bit;
                  state_q      <= done_state;
                end
              end else begin
                pending_q <= byte_q;
                phase_q   <= PH_REF_HI;
                state_q   <= done_state;
              end
            end
            PH_REF_HI: begin
              flag_bits_q  <= {flag_bits_q[6:0], 1'b0};
              flag_index_q <= flag_index_inc;
              phase_q      <= phase_after_bit;
              if ((error_q == lzsd_pkg::STATUS_OK) &&
                  ({{(lzsd_pkg::COUNT_W - lzsd_pkg::DIST_W){1'b0}}, ref_off} <
                   out_total_q)) begin
                src_q   <= out_total_q[AddrW-1:0] - AddrW'(1) - AddrW'(ref_off);
                len_q   <= ref_len;
                state_q <= ST_COPY_RD;
              end else begin
                if (error_q == lzsd_pkg::STATUS_OK) begin
                  error_q <= lzsd_pkg::STATUS_OFFSET;
                end
                state_q <= done_state;
              end
            end
            default: begin
              phase_q <= PH_HDR_LO;
              state_q <= done_state;
            end
          endcase
        end

        ST_COPY_RD: begin
          if (hist_re) begin
            state_q <= ST_COPY_WR;
          end else begin
            state_q <= done_state;
          end
        end

        ST_COPY_WR: begin
          if (copy_emit) begin
            src_q   <= src_q + AddrW'(1);
            len_q   <= len_q - lzsd_pkg::LEN_W'(1);
            state_q <= ST_COPY_RD;
          end
        end

        ST_END: begin
          if (out_free) begin
            // Start the next stream from a clean parse state; history is kept.
            flag_bits_q  <= '0;
            flag_index_q <= '0;
            phase_q      <= PH_HDR_LO;
            pending_q    <= '0;
            hdr_len_q    <= '0;
            seen_q       <= '0;
            error_q      <= lzsd_pkg::STATUS_OK;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_end_q;
  assign m_axis_tdata_o  = {6'd0, out_count_q, out_status_q, out_byte_q};

  // History is only written below the output limit.
  `LZSD_ASSERT_IMP(a_write_under_limit, hist_we, out_total_q < max_output_q,
                   "history write beyond max_output")
  // A copy only runs on a clean stream.
  `LZSD_ASSERT_IMP(a_copy_clean, state_q == ST_COPY_WR, error_q == lzsd_pkg::STATUS_OK,
                   "copy in progress after an error")
  // Byte results carry neither status nor count.
  `LZSD_ASSERT_IMP(a_byte_result_clean, m_axis_tvalid_o && !m_axis_tlast_o,
                   m_axis_tdata_o[25:8] == 18'd0, "byte result with status or count")
  // Closing a stream returns the counters to their start values.
  `LZSD_ASSERT_NXT(a_end_clears, end_load,
                   (out_total_q == '0) && (seen_q == '0) && (phase_q == PH_HDR_LO),
                   "stream state not cleared after end result")

endmodule
`default_nettype wire
